### rtl/ale_pkg.sv
// Package for the array list engine: item types, request and status codes,
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package ale_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int ITEM_WIDTH_DEF = 32;
	localparam logic [6:0] LIMIT_RST = 7'd64;
	localparam logic REG_LIST_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_READ   = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} st_code_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [6:0]  position;
		logic [31:0] value;
	} ale_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  found_position;
		logic [31:0] read_value;
		logic        matches_res;
		logic [6:0]  list_length;
		logic        is_empty;
	} ale_rsp_t;

	typedef struct packed {
		logic     load;
		logic     step;
		logic     wr_pend;
		logic     chk;
		logic     fin;
		logic     wval;
		logic     inc;
		logic     dec;
		st_code_t code;
	} ale_cmd_t;

	typedef struct packed {
		req_code_t op;
		logic      full;
		logic      ins_bad;
		logic      del_bad;
		logic      rd_bad;
		logic      more;
		logic      pend;
		logic      hit;
		logic      out_free;
	} ale_sts_t;

endpackage

`default_nettype wire

### rtl/ale_ctrl.sv
// Controller for the array list engine: sequences decide, walk and finish steps.
// Depends on ale_pkg.
`default_nettype none

module ale_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_stall,
	input  ale_pkg::ale_sts_t sts,
	output ale_pkg::ale_cmd_t cmd
);
	import ale_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_INS, S_DEL, S_SRCH, S_RD, S_FIN
	} state_t;

	state_t   state_q, state_d;
	st_code_t code_q, code_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				code_d = ST_OK;
				case (sts.op)
					REQ_INSERT: begin
						if (sts.full) begin
							code_d  = ST_FULL;
							state_d = S_FIN;
						end else if (sts.ins_bad) begin
							code_d  = ST_RANGE;
							state_d = S_FIN;
						end else begin
							state_d = S_INS;
						end
					end
					REQ_DELETE: begin
						if (sts.del_bad) begin
							code_d  = ST_RANGE;
							state_d = S_FIN;
						end else begin
							state_d = S_DEL;
						end
					end
					REQ_SEARCH: state_d = S_SRCH;
					default: begin
						if (sts.rd_bad) begin
							code_d  = ST_RANGE;
							state_d = S_FIN;
						end else begin
							state_d = S_RD;
						end
					end
				endcase
			end
			S_INS, S_DEL: begin
				cmd.step    = sts.more;
				cmd.wr_pend = 1'b1;
				if (!sts.more && !sts.pend)
					state_d = S_FIN;
			end
			S_SRCH: begin
				cmd.chk = 1'b1;
				if (sts.hit) begin
					state_d = S_FIN;
				end else begin
					cmd.step = sts.more;
					if (!sts.more && !sts.pend)
						state_d = S_FIN;
				end
			end
			S_RD: begin
				cmd.step = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin  = 1'b1;
					cmd.wval = (sts.op == REQ_INSERT) && (code_q == ST_OK);
					cmd.inc  = (sts.op == REQ_INSERT) && (code_q == ST_OK);
					cmd.dec  = (sts.op == REQ_DELETE) && (code_q == ST_OK);
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

`default_nettype wire

### rtl/ale_dp.sv
// Datapath for the array list engine: list RAM, length and limit registers,
// walk pointer with one-deep read pipeline, result register. Depends on ale_pkg.
`default_nettype none

module ale_dp #(
	parameter int DEPTH      = ale_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = ale_pkg::ITEM_WIDTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  ale_pkg::ale_req_t req_item,
	input  ale_pkg::ale_cmd_t cmd,
	output ale_pkg::ale_sts_t sts,
	input  wire               cfg_we,
	input  wire  [6:0]        cfg_data,
	output logic [6:0]        list_limit,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output ale_pkg::ale_rsp_t rsp_data
);
	import ale_pkg::*;

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMPW = ($clog2(DEPTH + 1) > 7) ? $clog2(DEPTH + 1) : 7;

	function automatic logic [AW-1:0] to_addr(input logic [6:0] x);
		logic [AW+6:0] w;
		w = {{AW{1'b0}}, x};
		return w[AW-1:0];
	endfunction

	function automatic logic [ITEM_WIDTH-1:0] to_item(input logic [31:0] v);
		logic [ITEM_WIDTH+31:0] w;
		w = {{ITEM_WIDTH{1'b0}}, v};
		return w[ITEM_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] to_word(input logic [ITEM_WIDTH-1:0] d);
		logic [ITEM_WIDTH+31:0] w;
		w = {32'b0, d};
		return w[31:0];
	endfunction

	logic [ITEM_WIDTH-1:0] mem [DEPTH];

	req_code_t             op_q;
	logic [6:0]            pos_q;
	logic [ITEM_WIDTH-1:0] val_q;
	logic [6:0]            count_q, limit_q, ptr_q, found_q;
	logic                  pend_s1;
	logic [6:0]            pidx_s1;
	logic [ITEM_WIDTH-1:0] rdata_s1;
	logic                  rsp_valid_q;
	ale_rsp_t              rsp_q;

	logic [CMPW+6:0]       count_pad;
	logic [CMPW-1:0]       count_w;
	logic [6:0]            count_nx, rd_ptr, wr_ptr;
	logic                  we;
	logic [ITEM_WIDTH-1:0] wdata;
	logic                  rd_ok;

	assign count_pad = {{CMPW{1'b0}}, count_q};
	assign count_w   = count_pad[CMPW-1:0];

	always_comb begin
		sts          = '0;
		sts.op       = op_q;
		sts.full     = (count_q >= limit_q) || (count_w >= CMPW'(DEPTH));
		sts.ins_bad  = pos_q > count_q;
		sts.del_bad  = (pos_q == 7'd0) || (pos_q > count_q);
		sts.rd_bad   = pos_q >= count_q;
		sts.more     = (op_q == REQ_INSERT) ? (ptr_q > pos_q) : (ptr_q < count_q);
		sts.pend     = pend_s1;
		sts.hit      = pend_s1 && (rdata_s1 == val_q);
		sts.out_free = !rsp_valid_q || !rsp_stall;
	end

	assign rd_ptr = (op_q == REQ_INSERT) ? ptr_q - 7'd1 : ptr_q;

	always_comb begin
		we     = 1'b0;
		wr_ptr = pos_q;
		wdata  = val_q;
		if (cmd.wr_pend && pend_s1) begin
			we     = 1'b1;
			wr_ptr = (op_q == REQ_INSERT) ? pidx_s1 : pidx_s1 - 7'd1;
			wdata  = rdata_s1;
		end else if (cmd.wval) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[to_addr(wr_ptr)] <= wdata;
		if (cmd.step)
			rdata_s1 <= mem[to_addr(rd_ptr)];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_code_t'(req_item.req_type);
			pos_q <= req_item.position;
			val_q <= to_item(req_item.value);
			case (req_code_t'(req_item.req_type))
				REQ_INSERT: ptr_q <= count_q;
				REQ_SEARCH: ptr_q <= 7'd0;
				default:    ptr_q <= req_item.position;
			endcase
		end else if (cmd.step) begin
			ptr_q <= (op_q == REQ_INSERT) ? ptr_q - 7'd1 : ptr_q + 7'd1;
		end
		if (cmd.step)
			pidx_s1 <= ptr_q;
		if (cmd.load)
			found_q <= 7'd0;
		else if (cmd.chk && pend_s1 && (rdata_s1 == val_q))
			found_q <= pidx_s1 + 7'd1;
	end

	assign count_nx = count_q + {6'd0, cmd.inc} - {6'd0, cmd.dec};
	assign rd_ok    = (op_q == REQ_READ) && (cmd.code == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 7'd0;
			limit_q     <= LIMIT_RST;
			pend_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			pend_s1 <= cmd.step;
			if (cfg_we)
				limit_q <= cfg_data;
			if (cmd.fin)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			rsp_q.status         <= cmd.code;
			rsp_q.found_position <= found_q;
			rsp_q.read_value     <= rd_ok ? to_word(rdata_s1) : 32'd0;
			rsp_q.matches_res    <= rd_ok && (rdata_s1 == val_q);
			rsp_q.list_length    <= count_nx;
			rsp_q.is_empty       <= (count_nx == 7'd0);
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign rsp_data   = rsp_q;
	assign list_limit = limit_q;

endmodule

`default_nettype wire

### rtl/array_list_engine_core.sv
// Top level of the array list engine: APB register decode, controller and datapath.
// Depends on ale_pkg, ale_ctrl and ale_dp.
//
// Ordered list of up to DEPTH words held in a single-port-write, one-read RAM. One
// request at a time. Insert and delete move every element above the position one
// word per cycle; search reads elements in order until the first match or the end
// of the list. The worst case is a search that misses on a full list, set by the
// walk through the RAM port. A finished result sits in an output register, so the
// next item is taken while it waits; that item's own result then holds until the
// waiting one is taken. list_limit (byte address 0) caps the length at
// min(list_limit, DEPTH); write it only while idle.
`default_nettype none

module array_list_engine_core #(
	parameter int DEPTH      = ale_pkg::DEPTH_DEF,
	parameter int ITEM_WIDTH = ale_pkg::ITEM_WIDTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  ale_pkg::ale_req_t req_item,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output ale_pkg::ale_rsp_t rsp_data,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire  [2:0]        paddr,
	input  wire  [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import ale_pkg::*;

	ale_cmd_t   cmd;
	ale_sts_t   sts;
	logic       cfg_we;
	logic [6:0] limit;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_LIST_LIMIT);
	assign prdata = (paddr[2] == REG_LIST_LIMIT) ? {25'd0, limit} : 32'd0;

	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ale_dp #(
		.DEPTH      (DEPTH),
		.ITEM_WIDTH (ITEM_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_item   (req_item),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_data   (pwdata[6:0]),
		.list_limit (limit),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp_data   (rsp_data)
	);

	// a result is only loaded into a free output slot
	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.out_free)
		else $error("result loaded over a waiting result");

	// shift write-back and value write never share the RAM port
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wval && cmd.wr_pend && sts.pend))
		else $error("RAM write conflict");

	// an accepted item keeps the block busy on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("item accepted without going busy");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.is_empty == (rsp_data.list_length == 7'd0)))
		else $error("empty flag disagrees with length");

endmodule

`default_nettype wire

### tb/sv/tb_array_list_engine_core.sv
// Testbench for array_list_engine_core: ordered-list requests checked against a local list model.
// Depends on ale_pkg and the array_list_engine_core RTL; list_limit is set through the APB port.
`default_nettype none

module tb_array_list_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	import ale_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int SETTLE_CYCLES = LIST_DEPTH + 16;
	localparam logic [2:0] LIMIT_ADDR = {REG_LIST_LIMIT, 2'b00};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	ale_req_t    req_item = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	ale_rsp_t    rsp_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// list model
	logic [31:0] list_mem [LIST_DEPTH];
	int          list_len = 0;
	int          list_cap_reg = int'(LIMIT_RST);

	ale_rsp_t    pending_rsp [$];
	ale_rsp_t    want;
	int          mismatches = 0;
	int          hold_cycles = 0;
	int          stall_left = 0;
	bit          send_gaps_on = 1'b1;
	bit          rsp_gaps_on = 1'b1;

	array_list_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #4 clk = ~clk;

	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic ale_rsp_t apply_list_req(ale_req_t r);
		ale_rsp_t o;
		int       cap;
		int       p;
		o = '0;
		p = int'(r.position);
		cap = (list_cap_reg < LIST_DEPTH) ? list_cap_reg : LIST_DEPTH;
		case (r.req_type)
			REQ_INSERT: begin
				if (list_len >= cap)
					o.status = ST_FULL;
				else if (p > list_len)
					o.status = ST_RANGE;
				else begin
					for (int i = list_len; i > p; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[p] = r.value;
					list_len++;
				end
			end
			REQ_DELETE: begin
				if (p == 0 || p > list_len)
					o.status = ST_RANGE;
				else begin
					for (int i = p - 1; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i+1];
					list_len--;
				end
			end
			REQ_SEARCH: begin
				for (int i = 0; i < list_len; i++) begin
					if (list_mem[i] == r.value && o.found_position == '0)
						o.found_position = 7'(i + 1);
				end
			end
			default: begin
				if (p >= list_len)
					o.status = ST_RANGE;
				else begin
					o.read_value = list_mem[p];
					o.matches_res = (list_mem[p] == r.value);
				end
			end
		endcase
		o.list_length = 7'(list_len);
		o.is_empty = (list_len == 0);
		return o;
	endfunction

	// Mostly well-formed requests against the current list, some out-of-range noise.
	function automatic ale_req_t random_req(int ins_pct);
		ale_req_t r;
		int       pick;
		bit       noise;
		pick = $urandom_range(0, 99);
		noise = ($urandom_range(0, 9) == 0);
		r.value = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : $urandom;
		r.position = 7'($urandom_range(0, LIST_DEPTH));
		if (pick < ins_pct) begin
			r.req_type = REQ_INSERT;
			if (!noise)
				r.position = 7'($urandom_range(0, list_len));
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					r.req_type = REQ_DELETE;
					if (!noise)
						r.position = (list_len == 0) ? 7'd0 : 7'($urandom_range(1, list_len));
				end
				1: begin
					r.req_type = REQ_SEARCH;
					if (list_len > 0 && $urandom_range(0, 1) == 1)
						r.value = list_mem[$urandom_range(0, list_len - 1)];
				end
				default: begin
					r.req_type = REQ_READ;
					if (!noise && list_len > 0) begin
						r.position = 7'($urandom_range(0, list_len - 1));
						if ($urandom_range(0, 1) == 1)
							r.value = list_mem[r.position];
					end
				end
			endcase
		end
		return r;
	endfunction

	// Valid stays high after acceptance so back-to-back items need no extra edge.
	task automatic send_item(input ale_req_t r);
		int gap;
		gap = send_gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(apply_list_req(r));
	endtask

	task automatic send_op(input req_code_t op, input int pos, input logic [31:0] v);
		ale_req_t r;
		r.req_type = op;
		r.position = 7'(pos);
		r.value = v;
		send_item(r);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_list_limit(input int lim);
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= 32'(lim);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		list_cap_reg = lim;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[6:0] !== 7'(lim)) begin
			mismatches++;
			if (mismatches <= 10)
				$display("list_limit readback: exp %0d got %0d", lim, prdata[6:0]);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_op(REQ_READ, 0, 32'h0);
		send_op(REQ_DELETE, 0, 32'h0);
		send_op(REQ_DELETE, 1, 32'h0);
		send_op(REQ_SEARCH, 0, 32'h0);
		send_op(REQ_INSERT, 1, 32'h1);
		send_op(REQ_INSERT, 0, 32'h0);
		send_op(REQ_INSERT, 1, 32'hFFFF_FFFF);
		send_op(REQ_INSERT, 0, 32'h5555_5555);
		send_op(REQ_INSERT, 2, 32'hAAAA_AAAA);
		send_op(REQ_INSERT, 4, 32'h0);
		send_op(REQ_INSERT, 64, 32'h1);
		send_op(REQ_SEARCH, 0, 32'h0);
		send_op(REQ_SEARCH, 0, 32'hFFFF_FFFF);
		send_op(REQ_SEARCH, 0, 32'h1234_5678);
		send_op(REQ_READ, 0, 32'h5555_5555);
		send_op(REQ_READ, 3, 32'h0);
		send_op(REQ_READ, 5, 32'h0);
		send_op(REQ_READ, 64, 32'h0);
		send_op(REQ_DELETE, 0, 32'h0);
		send_op(REQ_DELETE, 6, 32'h0);
		send_op(REQ_DELETE, 2, 32'h0);
		send_op(REQ_DELETE, 4, 32'h0);
		send_op(REQ_DELETE, 1, 32'h0);
		send_op(REQ_SEARCH, 0, 32'hAAAA_AAAA);
		drain_results();
	endtask

	task automatic test_list_limit();
		write_list_limit(3);
		send_op(REQ_INSERT, 2, $urandom);
		send_op(REQ_INSERT, 0, $urandom);
		send_op(REQ_INSERT, 9, $urandom);
		write_list_limit(0);
		send_op(REQ_DELETE, 1, 32'h0);
		send_op(REQ_INSERT, 0, $urandom);
		send_op(REQ_SEARCH, 0, list_mem[1]);
		write_list_limit(1);
		send_op(REQ_INSERT, 5, $urandom);
		send_op(REQ_DELETE, 2, 32'h0);
		send_op(REQ_DELETE, 1, 32'h0);
		send_op(REQ_INSERT, 0, $urandom);
		send_op(REQ_INSERT, 1, $urandom);
		write_list_limit(64);
		while (list_len < LIST_DEPTH)
			send_op(REQ_INSERT, $urandom_range(0, list_len), $urandom);
		send_op(REQ_INSERT, 0, $urandom);
		send_op(REQ_READ, 63, list_mem[63]);
		send_op(REQ_SEARCH, 0, list_mem[63]);
		send_op(REQ_DELETE, 64, 32'h0);
		send_op(REQ_INSERT, 63, 32'hFFFF_FFFF);
		send_op(REQ_DELETE, 1, 32'h0);
		send_op(REQ_READ, 0, 32'h0);
		drain_results();
	endtask

	task automatic test_backpressure();
		send_gaps_on = 1'b0;
		rsp_gaps_on = 1'b0;
		hold_cycles = 300;
		repeat (16) send_item(random_req(40));
		drain_results();
		send_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
		repeat (8) send_item(random_req(40));
		drain_results();
	endtask

	task automatic test_random();
		int lim;
		int ins_pct;
		for (int ph = 0; ph < 6; ph++) begin
			ins_pct = 35;
			case (ph)
				0: lim = 64;
				1: lim = $urandom_range(2, 63);
				2: lim = 0;
				3: begin
					lim = 64;
					ins_pct = 65;
				end
				4: lim = 1;
				default: lim = $urandom_range(0, 64);
			endcase
			write_list_limit(lim);
			send_gaps_on = (ph != 3);
			rsp_gaps_on = (ph != 3);
			repeat (80) send_item(random_req(ins_pct));
			drain_results();
		end
		send_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			rsp_stall <= 1'b0;
			if (rsp_gaps_on)
				stall_left = idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d len %0d", rsp_data.status,
						rsp_data.list_length);
			end else begin
				want = pending_rsp.pop_front();
				if (rsp_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp/got: st %0d/%0d pos %0d/%0d rd %h/%h m %0d/%0d len %0d/%0d e %0d/%0d",
							want.status, rsp_data.status,
							want.found_position, rsp_data.found_position,
							want.read_value, rsp_data.read_value,
							want.matches_res, rsp_data.matches_res,
							want.list_length, rsp_data.list_length,
							want.is_empty, rsp_data.is_empty);
				end
			end
		end
	end

	initial begin
		#6_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_list_limit();
		test_backpressure();
		test_random();
		drain_results();
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/ale_pkg.sv
rtl/ale_ctrl.sv
rtl/ale_dp.sv
rtl/array_list_engine_core.sv
tb/sv/tb_array_list_engine_core.sv
